// File: rtl/sstg_pkg.sv
package sstg_pkg;

    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned ACC_W       = 48;
    localparam int unsigned MOD_W       = 42;
    localparam int unsigned IDX_W       = 18;
    localparam int unsigned FRAME_W     = 24;
    localparam int unsigned FRAC_W      = 24;
    localparam int unsigned CNT_W       = 6;
    localparam int unsigned MOD_STEPS   = 48;
    localparam int unsigned MUL_STEPS   = 36;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SAMPLE_RATE     = 3'd0,
        REG_START_FREQUENCY = 3'd1,
        REG_FREQUENCY_STEP  = 3'd2,
        REG_TOTAL_SAMPLES   = 3'd3,
        REG_CHANNEL_COUNT   = 3'd4,
        REG_SAMPLE_FORMAT   = 3'd5,
        REG_BIG_ENDIAN      = 3'd6
    } sstg_reg_t;

    typedef enum logic [1:0] {
        FMT_U8  = 2'd0,
        FMT_S8  = 2'd1,
        FMT_U16 = 2'd2,
        FMT_S16 = 2'd3
    } sstg_fmt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_FIX,
        ST_MUL,
        ST_DIV,
        ST_ROM,
        ST_ENC,
        ST_EMIT
    } sstg_state_t;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic mod_fix;
        logic mul_step;
        logic mul_add;
        logic div_step;
        logic rom_rd;
        logic enc;
        logic emit_next;
    } sstg_cmd_t;

    typedef struct packed {
        logic emit_last;
    } sstg_status_t;

endpackage

// File: rtl/sstg_ctrl.sv
module sstg_ctrl #(
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  in_advance,
    input  logic                  out_ready,
    input  sstg_pkg::sstg_status_t status,
    output sstg_pkg::sstg_cmd_t    cmd,
    output logic                  in_ready,
    output logic                  out_valid
);
    import sstg_pkg::*;

    localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(MOD_STEPS - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SINE_TABLE_BITS + 1);

    sstg_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid && in_advance) state_next = ST_MOD;
            ST_MOD:  if (cnt_reg == MOD_LAST) state_next = ST_FIX;
            ST_FIX:  state_next = ST_MUL;
            ST_MUL:  if (cnt_reg == MUL_LAST) state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == DIV_LAST) state_next = ST_ROM;
            ST_ROM:  state_next = ST_ENC;
            ST_ENC:  state_next = ST_EMIT;
            ST_EMIT: if (out_ready && status.emit_last) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        cnt_next = (state_next != state_reg) ? '0 : cnt_reg + CNT_W'(1);
    end

    always_comb begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MOD:  cmd.mod_step = 1'b1;
            ST_FIX:  cmd.mod_fix = 1'b1;
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                cmd.mul_add  = cnt_reg[0];
            end
            ST_DIV:  cmd.div_step = 1'b1;
            ST_ROM:  cmd.rom_rd = 1'b1;
            ST_ENC:  cmd.enc = 1'b1;
            ST_EMIT: begin
                out_valid     = 1'b1;
                cmd.emit_next = out_ready;
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/sstg_datapath.sv
module sstg_datapath #(
    parameter int unsigned SINE_TABLE_BITS = 10,
    parameter int unsigned AMPLITUDE_BITS  = 16,
    parameter int unsigned MAX_CHANNELS    = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sstg_pkg::sstg_cmd_t                cmd,
    output sstg_pkg::sstg_status_t             status,
    input  logic                              in_advance,
    input  logic                              in_restart,
    input  logic                              cfg_wen,
    input  logic [sstg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [sstg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic [15:0]                       sample_word,
    output logic [2:0]                        channel_number,
    output logic                              last_of_frame,
    output logic                              sweep_wrapped
);
    import sstg_pkg::*;

    localparam int unsigned T     = SINE_TABLE_BITS;
    localparam int unsigned AW    = AMPLITUDE_BITS;
    localparam int unsigned DEPTH = (1 << T) + 1;
    localparam int unsigned CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    typedef logic [AW-1:0] rom_t [0:DEPTH-1];

    function automatic logic [AW-1:0] rom_val(int unsigned k);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (64'(k) * 64'(HALF_PI_Q30)) >> T;
        term = x;
        sum  = x;
        for (int unsigned i = 1; i <= 6; i++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            // taylor series divisors (2i)(2i+1)
            case (i)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if (i % 2 == 1) sum = sum - term;
            else            sum = sum + term;
        end
        return AW'(((sum << (AW - 1)) + (64'd1 << 29)) >> 30);
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int unsigned k = 0; k < DEPTH; k++) r[k] = rom_val(k);
        return r;
    endfunction

    localparam rom_t ROM = build_rom();

    // configuration
    logic [17:0] fs_reg, start_reg;
    logic [31:0] step_reg;
    logic [23:0] total_reg;
    logic [3:0]  chans_reg;
    logic [1:0]  fmt_reg;
    logic        be_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_reg    <= 18'd44100;
            start_reg <= 18'd440;
            step_reg  <= '0;
            total_reg <= 24'd44100;
            chans_reg <= 4'd1;
            fmt_reg   <= FMT_S16;
            be_reg    <= 1'b0;
        end else if (cfg_wen) begin
            case (cfg_addr)
                REG_SAMPLE_RATE:     fs_reg    <= cfg_wdata[17:0];
                REG_START_FREQUENCY: start_reg <= cfg_wdata[17:0];
                REG_FREQUENCY_STEP:  step_reg  <= cfg_wdata;
                REG_TOTAL_SAMPLES:   total_reg <= cfg_wdata[23:0];
                REG_CHANNEL_COUNT:   chans_reg <= cfg_wdata[3:0];
                REG_SAMPLE_FORMAT:   fmt_reg   <= cfg_wdata[1:0];
                REG_BIG_ENDIAN:      be_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // sweep state
    logic [ACC_W-1:0]   acc_reg, acc_use, acc_step;
    logic [FRAME_W-1:0] fi_reg, fi_use, fi_inc;
    logic [IDX_W-1:0]   idx_reg, idx_use, idx_inc;
    logic               wrap_now, wrap_reg;
    logic [ACC_W-1:0]   start_acc;

    assign start_acc = {6'd0, start_reg, {FRAC_W{1'b0}}};
    assign acc_use   = in_restart ? start_acc : acc_reg;
    assign fi_use    = in_restart ? '0 : fi_reg;
    assign idx_use   = in_restart ? '0 : idx_reg;
    assign acc_step  = acc_use + {{(ACC_W-32){step_reg[31]}}, step_reg};
    assign fi_inc    = fi_use + FRAME_W'(1);
    assign idx_inc   = idx_use + IDX_W'(1);
    assign wrap_now  = (fi_inc >= total_reg) || (fi_inc == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= {6'd0, 18'd440, {FRAC_W{1'b0}}};
            fi_reg  <= '0;
            idx_reg <= '0;
        end else if (cmd.load) begin
            if (!in_advance) begin
                acc_reg <= acc_use;
                fi_reg  <= fi_use;
                idx_reg <= idx_use;
            end else if (wrap_now) begin
                acc_reg <= start_acc;
                fi_reg  <= '0;
                idx_reg <= '0;
            end else begin
                acc_reg <= acc_step;
                fi_reg  <= fi_inc;
                idx_reg <= (idx_inc >= fs_reg) ? '0 : idx_inc;
            end
        end
    end

    // phase arithmetic: one shared compare and subtract against Fs*2^24
    logic [MOD_W-1:0] modv, r_reg, res_reg, r_cs;
    logic [MOD_W:0]   t;
    logic [ACC_W-1:0] num_reg;
    logic [IDX_W-1:0] m_reg;
    logic             neg_reg;
    logic [T+1:0]     p_reg;
    logic             ge;

    assign modv = {fs_reg, {FRAC_W{1'b0}}};

    always_comb begin
        if (cmd.mod_step)
            t = {r_reg, num_reg[ACC_W-1]};
        else if (cmd.mul_step && cmd.mul_add)
            t = m_reg[IDX_W-1] ? ({1'b0, r_reg} + {1'b0, res_reg}) : {1'b0, r_reg};
        else
            t = {r_reg, 1'b0};
        ge   = t >= {1'b0, modv};
        r_cs = ge ? MOD_W'(t - {1'b0, modv}) : t[MOD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            num_reg  <= acc_use[ACC_W-1] ? (ACC_W'(0) - acc_use) : acc_use;
            neg_reg  <= acc_use[ACC_W-1];
            m_reg    <= idx_use;
            r_reg    <= '0;
            p_reg    <= '0;
            wrap_reg <= wrap_now;
        end
        if (cmd.mod_step) begin
            r_reg   <= r_cs;
            num_reg <= {num_reg[ACC_W-2:0], 1'b0};
        end
        if (cmd.mod_fix) begin
            res_reg <= (neg_reg && r_reg != '0) ? (modv - r_reg) : r_reg;
            r_reg   <= '0;
        end
        if (cmd.mul_step) begin
            r_reg <= r_cs;
            if (cmd.mul_add) m_reg <= {m_reg[IDX_W-2:0], 1'b0};
        end
        if (cmd.div_step) begin
            r_reg <= r_cs;
            p_reg <= {p_reg[T:0], ge};
        end
    end

    // quarter-wave lookup
    logic [T+1:0] p_use;
    logic [T:0]   addr;
    logic [AW-1:0] mag_reg;
    logic          q1_reg;

    assign p_use = (fs_reg == '0) ? '0 : p_reg;
    assign addr  = p_use[T] ? ((T+1)'(1 << T) - {1'b0, p_use[T-1:0]})
                            : {1'b0, p_use[T-1:0]};

    always_ff @(posedge aclk) begin
        if (cmd.rom_rd) begin
            mag_reg <= ROM[addr];
            q1_reg  <= p_use[T+1];
        end
    end

    // sample encoding
    logic          neg;
    logic [AW:0]   upos;
    logic [AW+8:0] u8p;
    logic [AW+6:0] s8p;
    logic [AW+16:0] u16p;
    logic [AW+14:0] s16p;
    logic [7:0]    s8v;
    logic [15:0]   s16v, w16, word_next, word_reg;

    always_comb begin
        neg  = q1_reg && (mag_reg != '0);
        upos = neg ? ((AW+1)'(1 << (AW - 1)) - {1'b0, mag_reg})
                   : ((AW+1)'(1 << (AW - 1)) + {1'b0, mag_reg});
        u8p  = (AW+9)'(upos) * (AW+9)'(255);
        u16p = (AW+17)'(upos) * (AW+17)'(65535);
        s8p  = (AW+7)'(mag_reg) * (AW+7)'(127);
        s16p = (AW+15)'(mag_reg) * (AW+15)'(32767);
        s8v  = neg ? (8'd0 - s8p[AW+6:AW-1]) : s8p[AW+6:AW-1];
        s16v = neg ? (16'd0 - s16p[AW+14:AW-1]) : s16p[AW+14:AW-1];
        w16  = (fmt_reg == FMT_U16) ? u16p[AW+15:AW] : s16v;
        case (fmt_reg)
            FMT_U8:  word_next = {8'd0, u8p[AW+7:AW]};
            FMT_S8:  word_next = {8'd0, s8v};
            default: word_next = be_reg ? {w16[7:0], w16[15:8]} : w16;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.enc) word_reg <= word_next;
    end

    // channel sequencing
    logic [CHW-1:0] ch_reg, ch_last;

    always_comb begin
        if (chans_reg == '0)
            ch_last = '0;
        else if (32'(chans_reg) > MAX_CHANNELS)
            ch_last = CHW'(MAX_CHANNELS - 1);
        else
            ch_last = CHW'(chans_reg - 4'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_reg <= '0;
        end else if (cmd.emit_next) begin
            ch_reg <= (ch_reg == ch_last) ? '0 : ch_reg + CHW'(1);
        end
    end

    assign status.emit_last = (ch_reg == ch_last);
    assign sample_word      = word_reg;
    assign channel_number   = 3'(ch_reg);
    assign last_of_frame    = (ch_reg == ch_last);
    assign sweep_wrapped    = wrap_reg;

endmodule

// File: rtl/swept_sine_tone_generator.sv
// channel  dir  ports                     contents
// s_       in   tvalid tready tdata[7:0]  advance, restart
// m_       out  tvalid tready tdata[15:0] sample_word
//                tlast tuser[3:0]         last_of_frame; channel_number, sweep_wrapped
// cfg_     in   wen addr[2:0] wdata[31:0] register writes, no read-back
// an item with advance set first takes phase work (bit-serial remainder, modular multiply and
// divide on one compare-subtract unit), then gives one result per channel at one per cycle
// while m_tready is high
// an item without advance is taken without starting a frame and only applies restart
// reset is synchronous, active low, and returns configuration and sweep to defaults
// results hold on m_ while m_tready is low; s_tready is low until the frame is delivered
module swept_sine_tone_generator #(
    parameter int unsigned SINE_TABLE_BITS = 10,
    parameter int unsigned AMPLITUDE_BITS  = 16,
    parameter int unsigned MAX_CHANNELS    = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [0] advance, [1] restart
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,  // [15:0] sample_word
    output logic                            m_tlast,
    output logic [3:0]                      m_tuser,  // [2:0] channel_number, [3] sweep_wrapped
    input  logic                            cfg_wen,
    input  logic [sstg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [sstg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import sstg_pkg::*;

    sstg_cmd_t    cmd;
    sstg_status_t status;

    sstg_ctrl #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_advance(s_tdata[0]),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (s_tready),
        .out_valid (m_tvalid)
    );

    sstg_datapath #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS),
        .AMPLITUDE_BITS (AMPLITUDE_BITS),
        .MAX_CHANNELS   (MAX_CHANNELS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .in_advance    (s_tdata[0]),
        .in_restart    (s_tdata[1]),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .sample_word   (m_tdata),
        .channel_number(m_tuser[2:0]),
        .last_of_frame (m_tlast),
        .sweep_wrapped (m_tuser[3])
    );

    a_out_blocks_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a frame is being delivered");

    a_channel_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tuser[2:0] == 3'($past(m_tuser[2:0]) + 3'd1)))
        else $error("channel sequence broken within a frame");

    a_idle_item_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tdata[0] |=> s_tready && !m_tvalid)
        else $error("item without advance started a frame");

    a_wrap_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tuser[3] == $past(m_tuser[3]))
        else $error("sweep flag changed within a frame");

endmodule
